// ===== sv/ata_tf_pkg.sv =====
// Shared widths, codes and constants for the ATA taskfile read sequencer.
package ata_tf_pkg;

   localparam int ADDR_W       = 32;
   localparam int SPT_W        = 8;
   localparam int HPC_W        = 5;
   localparam int MODE_W       = 2;
   localparam int KIND_W       = 2;
   localparam int REG_IDX_W    = 3;
   localparam int BYTE_W       = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;

   localparam int CHUNK_SECTORS_DEF = 64;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_REG_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PAST_END  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FAILED    = 2'd3;

   // taskfile register offsets
   localparam logic [REG_IDX_W-1:0] TF_COUNT  = 3'd2;
   localparam logic [REG_IDX_W-1:0] TF_SECTOR = 3'd3;
   localparam logic [REG_IDX_W-1:0] TF_CYL_LO = 3'd4;
   localparam logic [REG_IDX_W-1:0] TF_CYL_HI = 3'd5;
   localparam logic [REG_IDX_W-1:0] TF_HEAD   = 3'd6;
   localparam logic [REG_IDX_W-1:0] TF_CMD    = 3'd7;

   // command and head register bytes
   localparam logic [BYTE_W-1:0] CMD_READ     = 8'h20;
   localparam logic [BYTE_W-1:0] CMD_READ_EXT = 8'h24;
   localparam logic [BYTE_W-1:0] HEAD_LBA     = 8'h40;
   localparam logic [BYTE_W-1:0] HEAD_FIXED   = 8'hA0;
   localparam logic [BYTE_W-1:0] HEAD_DEV     = 8'h10;

   // address modes (anything else runs as LBA48)
   localparam logic [MODE_W-1:0] MODE_CHS   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LBA28 = 2'd1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPT          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HPC          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_SIZE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_SELECT = 3'd4;

   localparam logic [SPT_W-1:0] SPT_RESET = 8'd63;
   localparam logic [HPC_W-1:0] HPC_RESET = 5'd16;

endpackage

// ===== sv/ata_tf_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module ata_tf_divider #(
   parameter int DIVIDEND_W = ata_tf_pkg::ADDR_W,
   parameter int DIVISOR_W  = ata_tf_pkg::SPT_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      cnt_ff;
   logic                  done_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dvsr_ff;

   logic [DIVISOR_W:0] trial;
   logic [DIVISOR_W:0] diff;
   logic               ge;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dvsr_ff};
   assign ge    = (trial >= {1'b0, dvsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= CNT_W'(DIVIDEND_W);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_ff - CNT_W'(1);
         done_ff <= (cnt_ff == CNT_W'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvsr_ff <= divisor;
      end else if (cnt_ff != '0) begin
         // remainder stays below the divisor, so the low bits hold it
         rem_ff <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], ge};
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/ata_taskfile_read_sequencer_unit.sv =====
// ATA taskfile read sequencer: splits read requests into taskfile write items.
//
// Input channel (req_*): one item either starts a read request (req_type 0,
// with start sector and count) or reports the previous chunk finished
// (req_type 1, with req_chunk_ok). One item is worked on at a time; req_ready
// is high only while the sequencer waits for the next item.
// Result channel (rsp_*): each input item answers with up to nine items, the
// final one marked by rsp_last; a chunk-done while idle answers nothing.
// LBA28/LBA48 chunks pass from accept through the decode state to the emit
// state, then give one result per cycle while results are taken; a start in
// range with a nonzero count answers with the taskfile writes of the first
// chunk. CHS chunks first run two passes of the shared bit-serial divider
// (address / sectors per track, then track / heads) before the first write.
// The result register lets the last result wait while the next input item is
// already accepted. When rsp_ready is low the sequencer holds its current
// result and emits no further result until it is taken.
// Reset: configuration returns to CHS, 63 sectors per track, 16 heads, device
// size 0, master drive; no request is active and no result is pending.
// The user must write configuration (csr_*) only while the block is idle; the block itself does not enforce it.
module ata_taskfile_read_sequencer_unit #(
   parameter int CHUNK_SECTORS = ata_tf_pkg::CHUNK_SECTORS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_type,
   input  logic [ata_tf_pkg::ADDR_W-1:0]         req_start_sector,
   input  logic [ata_tf_pkg::ADDR_W-1:0]         req_sector_count,
   input  logic                                  req_chunk_ok,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ata_tf_pkg::KIND_W-1:0]         rsp_kind,
   output logic [ata_tf_pkg::REG_IDX_W-1:0]      rsp_reg_index,
   output logic [ata_tf_pkg::BYTE_W-1:0]         rsp_reg_value,
   output logic                                  rsp_last,
   input  logic                                  csr_we,
   input  logic [ata_tf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ata_tf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = ata_tf_pkg::ADDR_W;
   localparam int BW = ata_tf_pkg::BYTE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_TRACK_GO,
      ST_TRACK_WAIT,
      ST_CYL_GO,
      ST_CYL_WAIT,
      ST_EMIT
   } state_type;

   // configuration
   logic [ata_tf_pkg::MODE_W-1:0] mode_ff;
   logic [ata_tf_pkg::SPT_W-1:0]  spt_ff;
   logic [ata_tf_pkg::HPC_W-1:0]  hpc_ff;
   logic [AW-1:0]                 size_ff;
   logic                          slave_ff;

   // sequencer
   state_type                     state_ff;
   logic                          type_ff;
   logic [AW-1:0]                 start_ff;
   logic [AW-1:0]                 count_ff;
   logic                          ok_ff;
   logic [AW-1:0]                 cur_ff;
   logic [AW-1:0]                 left_ff;
   logic                          active_ff;
   logic [3:0]                    step_ff;
   logic [ata_tf_pkg::KIND_W-1:0] single_ff;
   logic [BW-1:0]                 sector_ff;
   logic [3:0]                    head_ff;
   logic [15:0]                   cyl_ff;

   logic                                rsp_valid_ff;
   logic [ata_tf_pkg::KIND_W-1:0]       rsp_kind_ff;
   logic [ata_tf_pkg::REG_IDX_W-1:0]    rsp_idx_ff;
   logic [BW-1:0]                       rsp_val_ff;
   logic                                rsp_last_ff;

   // shared divider
   logic                         div_start;
   logic [AW-1:0]                div_dividend;
   logic [ata_tf_pkg::SPT_W-1:0] div_divisor;
   logic                         div_done;
   logic [AW-1:0]                div_quo;
   logic [ata_tf_pkg::SPT_W-1:0] div_rem;

   logic [ata_tf_pkg::SPT_W-1:0] spt_eff;
   logic [ata_tf_pkg::HPC_W-1:0] hpc_eff;
   logic                         past_end;
   logic [BW-1:0]                nsect;
   logic [AW-1:0]                left_next;
   logic [BW-1:0]                dev;

   logic [ata_tf_pkg::KIND_W-1:0]    out_kind;
   logic [ata_tf_pkg::REG_IDX_W-1:0] out_idx;
   logic [BW-1:0]                    out_val;
   logic                             out_last;
   logic                             out_take;

   assign spt_eff = (spt_ff == '0) ? ata_tf_pkg::SPT_W'(1) : spt_ff;
   assign hpc_eff = (hpc_ff == '0) ? ata_tf_pkg::HPC_W'(1) : hpc_ff;
   assign past_end = ({1'b0, start_ff} + {1'b0, count_ff}) > {1'b0, size_ff};
   assign nsect = (left_ff > AW'(CHUNK_SECTORS)) ? BW'(CHUNK_SECTORS) : left_ff[BW-1:0];
   assign left_next = left_ff - {{(AW-BW){1'b0}}, nsect};
   assign dev = slave_ff ? ata_tf_pkg::HEAD_DEV : '0;

   assign div_start    = (state_ff == ST_TRACK_GO) || (state_ff == ST_CYL_GO);
   assign div_dividend = (state_ff == ST_CYL_GO) ? div_quo : cur_ff;
   assign div_divisor  = (state_ff == ST_CYL_GO)
                         ? ata_tf_pkg::SPT_W'(hpc_eff) : spt_eff;

   ata_tf_divider #(
      .DIVIDEND_W (AW),
      .DIVISOR_W  (ata_tf_pkg::SPT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ata_tf_pkg::MODE_CHS;
         spt_ff   <= ata_tf_pkg::SPT_RESET;
         hpc_ff   <= ata_tf_pkg::HPC_RESET;
         size_ff  <= '0;
         slave_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            ata_tf_pkg::CSR_ADDRESS_MODE: mode_ff <= csr_wdata[ata_tf_pkg::MODE_W-1:0];
            ata_tf_pkg::CSR_SPT:          spt_ff  <= csr_wdata[ata_tf_pkg::SPT_W-1:0];
            ata_tf_pkg::CSR_HPC:          hpc_ff  <= csr_wdata[ata_tf_pkg::HPC_W-1:0];
            ata_tf_pkg::CSR_DEVICE_SIZE:  size_ff <= csr_wdata[AW-1:0];
            ata_tf_pkg::CSR_SLAVE_SELECT: slave_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // next result item from mode and step
   always_comb begin
      out_kind = single_ff;
      out_idx  = '0;
      out_val  = '0;
      out_last = 1'b1;
      if (single_ff == ata_tf_pkg::KIND_REG_WRITE) begin
         out_last = 1'b0;
         if (mode_ff == ata_tf_pkg::MODE_CHS) begin
            case (step_ff)
               4'd0: begin out_idx = ata_tf_pkg::TF_SECTOR; out_val = sector_ff; end
               4'd1: begin
                  out_idx = ata_tf_pkg::TF_HEAD;
                  out_val = ata_tf_pkg::HEAD_FIXED | dev | {4'b0, head_ff};
               end
               4'd2: begin out_idx = ata_tf_pkg::TF_CYL_HI; out_val = cyl_ff[15:8]; end
               4'd3: begin out_idx = ata_tf_pkg::TF_CYL_LO; out_val = cyl_ff[7:0]; end
               4'd4: begin out_idx = ata_tf_pkg::TF_COUNT; out_val = nsect; end
               default: begin
                  out_idx  = ata_tf_pkg::TF_CMD;
                  out_val  = ata_tf_pkg::CMD_READ;
                  out_last = 1'b1;
               end
            endcase
         end else if (mode_ff == ata_tf_pkg::MODE_LBA28) begin
            case (step_ff)
               4'd0: begin
                  out_idx = ata_tf_pkg::TF_HEAD;
                  out_val = ata_tf_pkg::HEAD_FIXED | ata_tf_pkg::HEAD_LBA | dev
                            | {4'b0, cur_ff[27:24]};
               end
               4'd1: begin out_idx = ata_tf_pkg::TF_CYL_HI; out_val = cur_ff[23:16]; end
               4'd2: begin out_idx = ata_tf_pkg::TF_CYL_LO; out_val = cur_ff[15:8]; end
               4'd3: begin out_idx = ata_tf_pkg::TF_SECTOR; out_val = cur_ff[7:0]; end
               4'd4: begin out_idx = ata_tf_pkg::TF_COUNT; out_val = nsect; end
               default: begin
                  out_idx  = ata_tf_pkg::TF_CMD;
                  out_val  = ata_tf_pkg::CMD_READ;
                  out_last = 1'b1;
               end
            endcase
         end else begin
            case (step_ff)
               4'd0: out_idx = ata_tf_pkg::TF_CYL_HI;
               4'd1: out_idx = ata_tf_pkg::TF_CYL_LO;
               4'd2: begin out_idx = ata_tf_pkg::TF_SECTOR; out_val = cur_ff[31:24]; end
               4'd3: out_idx = ata_tf_pkg::TF_COUNT;
               4'd4: begin out_idx = ata_tf_pkg::TF_CYL_HI; out_val = cur_ff[23:16]; end
               4'd5: begin out_idx = ata_tf_pkg::TF_CYL_LO; out_val = cur_ff[15:8]; end
               4'd6: begin out_idx = ata_tf_pkg::TF_SECTOR; out_val = cur_ff[7:0]; end
               4'd7: begin out_idx = ata_tf_pkg::TF_COUNT; out_val = nsect; end
               default: begin
                  out_idx  = ata_tf_pkg::TF_CMD;
                  out_val  = ata_tf_pkg::CMD_READ_EXT;
                  out_last = 1'b1;
               end
            endcase
         end
      end
   end

   assign out_take = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         cur_ff       <= '0;
         left_ff      <= '0;
         step_ff      <= '0;
         single_ff    <= ata_tf_pkg::KIND_REG_WRITE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop a taken result unless a new one is loaded now
         if (rsp_ready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               step_ff <= '0;
               if (!type_ff) begin
                  if (past_end) begin
                     active_ff <= 1'b0;
                     single_ff <= ata_tf_pkg::KIND_PAST_END;
                     state_ff  <= ST_EMIT;
                  end else if (count_ff == '0) begin
                     active_ff <= 1'b0;
                     single_ff <= ata_tf_pkg::KIND_DONE;
                     state_ff  <= ST_EMIT;
                  end else begin
                     cur_ff    <= start_ff;
                     left_ff   <= count_ff;
                     active_ff <= 1'b1;
                     single_ff <= ata_tf_pkg::KIND_REG_WRITE;
                     state_ff  <= (mode_ff == ata_tf_pkg::MODE_CHS) ? ST_TRACK_GO : ST_EMIT;
                  end
               end else if (!active_ff) begin
                  // chunk done with nothing running: drop it
                  state_ff <= ST_IDLE;
               end else if (!ok_ff) begin
                  active_ff <= 1'b0;
                  single_ff <= ata_tf_pkg::KIND_FAILED;
                  state_ff  <= ST_EMIT;
               end else begin
                  left_ff <= left_next;
                  cur_ff  <= cur_ff + AW'(CHUNK_SECTORS);
                  if (left_next == '0) begin
                     active_ff <= 1'b0;
                     single_ff <= ata_tf_pkg::KIND_DONE;
                     state_ff  <= ST_EMIT;
                  end else begin
                     single_ff <= ata_tf_pkg::KIND_REG_WRITE;
                     state_ff  <= (mode_ff == ata_tf_pkg::MODE_CHS) ? ST_TRACK_GO : ST_EMIT;
                  end
               end
            end
            ST_TRACK_GO: state_ff <= ST_TRACK_WAIT;
            ST_TRACK_WAIT: begin
               if (div_done) begin
                  state_ff <= ST_CYL_GO;
               end
            end
            ST_CYL_GO: state_ff <= ST_CYL_WAIT;
            ST_CYL_WAIT: begin
               if (div_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_take) begin
                  rsp_valid_ff <= 1'b1;
                  step_ff      <= step_ff + 4'd1;
                  if (out_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         type_ff  <= req_type;
         start_ff <= req_start_sector;
         count_ff <= req_sector_count;
         ok_ff    <= req_chunk_ok;
      end
      if (state_ff == ST_TRACK_WAIT && div_done) begin
         sector_ff <= div_rem + BW'(1);
      end
      if (state_ff == ST_CYL_WAIT && div_done) begin
         head_ff <= div_rem[3:0];
         cyl_ff  <= div_quo[15:0];
      end
      if (state_ff == ST_EMIT && out_take) begin
         rsp_kind_ff <= out_kind;
         rsp_idx_ff  <= out_idx;
         rsp_val_ff  <= out_val;
         rsp_last_ff <= out_last;
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_reg_index = rsp_idx_ff;
   assign rsp_reg_value = rsp_val_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== sv/ata_tf_checker.sv =====
// Port-level checks for the taskfile read sequencer, bound to the top level.
module ata_tf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [ata_tf_pkg::KIND_W-1:0]      rsp_kind,
   input logic [ata_tf_pkg::REG_IDX_W-1:0]   rsp_reg_index,
   input logic [ata_tf_pkg::BYTE_W-1:0]      rsp_reg_value,
   input logic                               rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_reg_index) && $stable(rsp_reg_value) && $stable(rsp_last))
      else $error("result changed while stalled");

   // status items stand alone
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != ata_tf_pkg::KIND_REG_WRITE |-> rsp_last
         && rsp_reg_index == '0 && rsp_reg_value == '0)
      else $error("status item not alone or carries register data");

   // the command write closes every chunk
   a_cmd_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ata_tf_pkg::KIND_REG_WRITE |->
         (rsp_reg_index == ata_tf_pkg::TF_CMD) == rsp_last)
      else $error("last flag does not match command write");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted twice in a row");

endmodule

bind ata_taskfile_read_sequencer_unit ata_tf_checker u_ata_tf_checker (.*);
